/* hw/rtl/ghalloc_pkg.sv */
// shared types and constants for the generational handle allocator
package ghalloc_pkg;

  localparam int unsigned SLOT_COUNT = 1024;
  localparam int unsigned IDX_W      = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned VER_W      = 32;
  localparam int unsigned HANDLE_W   = 64;

  localparam logic [VER_W-1:0] VERSION_SENTINEL = '1;

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_DESTROY = 2'd1,
    CMD_CHECK   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]          command;
    logic [HANDLE_W-1:0] handle_in;
  } in_item_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle_out;
    logic                is_valid;
    logic [1:0]          status;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [VER_W-1:0] ver;
  } stk_entry_t;

  typedef struct packed {
    logic capture;
    logic read;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

endpackage

/* hw/rtl/ghalloc_ctrl.sv */
// controller state machine sequencing capture, table read and update
module ghalloc_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  ghalloc_pkg::dp_status_t dp_status_i,
  output ghalloc_pkg::dp_cmd_t    dp_cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d           = state_q;
    in_ready_o        = 1'b0;
    dp_cmd_o          = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o       = 1'b1;
        dp_cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        dp_cmd_o.read = 1'b1;
        state_d       = S_EXEC;
      end
      S_EXEC: begin
        if (!dp_status_i.out_full) begin
          dp_cmd_o.exec = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/ghalloc_dp.sv */
// datapath: version table, free stack, counters and result register
module ghalloc_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ghalloc_pkg::in_item_t   in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output ghalloc_pkg::out_item_t  out_item_o,
  input  ghalloc_pkg::dp_cmd_t    dp_cmd_i,
  output ghalloc_pkg::dp_status_t dp_status_o
);

  localparam int unsigned IDX_W = ghalloc_pkg::IDX_W;
  localparam int unsigned CNT_W = ghalloc_pkg::CNT_W;
  localparam int unsigned VER_W = ghalloc_pkg::VER_W;

  logic [VER_W-1:0]        slot_version_mem [ghalloc_pkg::SLOT_COUNT];
  ghalloc_pkg::stk_entry_t free_stack_mem   [ghalloc_pkg::SLOT_COUNT];

  logic [1:0]                           cmd_q;
  logic [ghalloc_pkg::HANDLE_W-1:0]     handle_q;
  logic [VER_W-1:0]                     ver_rd_q;
  ghalloc_pkg::stk_entry_t              stk_rd_q;
  logic [CNT_W-1:0]                     free_count_q, free_count_d;
  logic [CNT_W-1:0]                     next_fresh_q, next_fresh_d;
  logic                                 out_valid_q;
  ghalloc_pkg::out_item_t               out_item_q, res;

  logic [VER_W-1:0]        h_idx_full;
  logic [VER_W-1:0]        h_ver;
  logic [IDX_W-1:0]        h_idx;
  logic [CNT_W-1:0]        stk_top;
  logic                    live;
  logic [VER_W-1:0]        pop_ver;
  logic                    ver_we;
  logic [IDX_W-1:0]        ver_waddr;
  logic [VER_W-1:0]        ver_wdata;
  logic                    stk_we;
  ghalloc_pkg::stk_entry_t stk_wdata;

  assign h_idx_full = handle_q[ghalloc_pkg::HANDLE_W-1:VER_W];
  assign h_ver      = handle_q[VER_W-1:0];
  assign h_idx      = handle_q[VER_W +: IDX_W];
  assign stk_top    = free_count_q - CNT_W'(1);

  assign live = (h_idx_full < {{(VER_W-CNT_W){1'b0}}, next_fresh_q}) &&
                (h_ver != ghalloc_pkg::VERSION_SENTINEL) &&
                (ver_rd_q == h_ver);

  always_comb begin
    pop_ver = stk_rd_q.ver + VER_W'(1);
    if (pop_ver == ghalloc_pkg::VERSION_SENTINEL) begin
      pop_ver = '0;
    end
  end

  always_comb begin
    res           = '0;
    ver_we        = 1'b0;
    ver_waddr     = next_fresh_q[IDX_W-1:0];
    ver_wdata     = '0;
    stk_we        = 1'b0;
    stk_wdata.idx = h_idx;
    stk_wdata.ver = h_ver;
    free_count_d  = free_count_q;
    next_fresh_d  = next_fresh_q;
    unique case (cmd_q)
      ghalloc_pkg::CMD_CREATE: begin
        if (free_count_q != '0) begin
          ver_we         = 1'b1;
          ver_waddr      = stk_rd_q.idx;
          ver_wdata      = pop_ver;
          free_count_d   = stk_top;
          res.handle_out = {{(VER_W-IDX_W){1'b0}}, stk_rd_q.idx, pop_ver};
        end else if (next_fresh_q != CNT_W'(ghalloc_pkg::SLOT_COUNT)) begin
          ver_we         = 1'b1;
          next_fresh_d   = next_fresh_q + CNT_W'(1);
          res.handle_out = {{(VER_W-IDX_W){1'b0}}, next_fresh_q[IDX_W-1:0],
                            {VER_W{1'b0}}};
        end else begin
          res.status = ghalloc_pkg::ST_FULL;
        end
      end
      ghalloc_pkg::CMD_DESTROY: begin
        if (live) begin
          res.is_valid = 1'b1;
          ver_we       = 1'b1;
          ver_waddr    = h_idx;
          ver_wdata    = ghalloc_pkg::VERSION_SENTINEL;
          if (free_count_q != CNT_W'(ghalloc_pkg::SLOT_COUNT)) begin
            stk_we       = 1'b1;
            free_count_d = free_count_q + CNT_W'(1);
          end
        end else begin
          res.status = ghalloc_pkg::ST_INVALID;
        end
      end
      ghalloc_pkg::CMD_CHECK: begin
        res.is_valid = live;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.capture) begin
      cmd_q    <= in_item_i.command;
      handle_q <= in_item_i.handle_in;
    end
    if (dp_cmd_i.read) begin
      ver_rd_q <= slot_version_mem[h_idx];
      stk_rd_q <= free_stack_mem[stk_top[IDX_W-1:0]];
    end
    if (dp_cmd_i.exec) begin
      out_item_q <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.exec && ver_we) begin
      slot_version_mem[ver_waddr] <= ver_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.exec && stk_we) begin
      free_stack_mem[free_count_q[IDX_W-1:0]] <= stk_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_count_q <= '0;
      next_fresh_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (dp_cmd_i.exec) begin
        free_count_q <= free_count_d;
        next_fresh_q <= next_fresh_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign dp_status_o.out_full = out_valid_q && !out_ready_i;
  assign out_valid_o          = out_valid_q;
  assign out_item_o           = out_item_q;

endmodule

/* hw/rtl/generational_handle_allocator_unit.sv */
// top level of the generational handle allocator
// sequencing: an accepted transaction is captured, then the version table and free stack
//   are read into registers, then the update state writes the result register; the update
//   waits while the output is full, and a new transaction is accepted only after it
// reset: free count and next fresh slot clear to zero, no clearing pass;
//   table contents are only read once written
module generational_handle_allocator_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  ghalloc_pkg::in_item_t  in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output ghalloc_pkg::out_item_t out_item_o
);

  ghalloc_pkg::dp_cmd_t    dp_cmd;
  ghalloc_pkg::dp_status_t dp_status;

  ghalloc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .dp_status_i (dp_status),
    .dp_cmd_o    (dp_cmd)
  );

  ghalloc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .dp_cmd_i    (dp_cmd),
    .dp_status_o (dp_status)
  );

endmodule
